/* rtl/core/mqttp_pkg.sv */
`timescale 1ns / 1ps

package mqttp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 256;

  localparam logic [15:0] TOPIC_CAP_RESET   = 16'd96;
  localparam logic [15:0] PAYLOAD_CAP_RESET = 16'd128;

  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] TYPE_PUBLISH = 8'h30;
  localparam logic [2:0] LEN_BYTES_MAX = 3'd5;

  typedef enum logic [1:0] {
    REG_TOPIC_CAP   = 2'd0,
    REG_PAYLOAD_CAP = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TOPIC   = 2'd1,
    KIND_PAYLOAD = 2'd2
  } byte_kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_NOT_PUBLISH  = 3'd2,
    ST_REM_EXCEEDS  = 3'd3,
    ST_NO_TOPIC_LEN = 3'd4,
    ST_TOPIC_OVERRUN = 3'd5,
    ST_NO_PACKET_ID = 3'd6,
    ST_TOO_LONG     = 3'd7
  } status_t;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  first_byte;
    logic        length_done;
    logic [2:0]  length_bytes_seen;
    logic [31:0] remaining_length;
    logic [15:0] declared_topic_length;
    logic [15:0] body_position;
    logic [15:0] kept_payload;
  } pkt_state_t;

  typedef struct packed {
    byte_kind_t  byte_kind;
    logic [7:0]  data_byte;
    logic        done_res;
    status_t     status;
    logic [1:0]  qos_level;
    logic [15:0] topic_length;
    logic [15:0] payload_kept;
  } result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
  endfunction

endpackage

/* rtl/core/mqttp_step.sv */
`timescale 1ns / 1ps

module mqttp_step (
  input  mqttp_pkg::pkt_state_t st,
  input  logic [7:0]            rx_byte,
  input  logic                  end_of_packet,
  input  logic [15:0]           topic_capacity,
  input  logic [15:0]           payload_capacity,
  output mqttp_pkg::pkt_state_t st_next,
  output mqttp_pkg::result_t    res
);

  logic        over;
  logic [7:0]  fb;
  logic        is_pub;
  logic [1:0]  qos;
  logic [15:0] topic_limit;
  logic [15:0] payload_limit;
  logic [6:0]  low7;
  logic [31:0] len_term;
  logic [16:0] topic_end;
  logic [17:0] payload_start;
  logic        may_tag;
  logic [15:0] body_cnt;
  logic [17:0] need;
  mqttp_pkg::byte_kind_t kind;
  mqttp_pkg::status_t    stat;

  always_comb begin
    over          = st.byte_count >= 16'(mqttp_pkg::MAX_PACKET_BYTES);
    fb            = (st.byte_count == 16'd0) ? rx_byte : st.first_byte;
    is_pub        = (fb & mqttp_pkg::TYPE_MASK) == mqttp_pkg::TYPE_PUBLISH;
    qos           = fb[2:1];
    topic_limit   = (topic_capacity != 16'd0) ? topic_capacity - 16'd1 : 16'd0;
    payload_limit = (payload_capacity != 16'd0) ? payload_capacity - 16'd1 : 16'd0;
    low7          = rx_byte[6:0];
    topic_end     = 17'd2 + {1'b0, st.declared_topic_length};
    payload_start = {1'b0, topic_end} + ((qos != 2'd0) ? 18'd2 : 18'd0);
    may_tag       = is_pub && !over;
    kind          = mqttp_pkg::KIND_NONE;

    unique case (st.length_bytes_seen)
      3'd0:    len_term = {25'd0, low7};
      3'd1:    len_term = {18'd0, low7, 7'd0};
      3'd2:    len_term = {11'd0, low7, 14'd0};
      3'd3:    len_term = {4'd0, low7, 21'd0};
      3'd4:    len_term = {low7[3:0], 28'd0};
      default: len_term = 32'd0;
    endcase

    st_next            = st;
    st_next.first_byte = fb;

    if (st.byte_count == 16'd0) begin
      // type byte
    end else if (!st.length_done) begin
      if (st.length_bytes_seen < mqttp_pkg::LEN_BYTES_MAX) begin
        st_next.remaining_length  = st.remaining_length + len_term;
        st_next.length_bytes_seen = st.length_bytes_seen + 3'd1;
      end
      if (!rx_byte[7]) begin
        st_next.length_done = 1'b1;
      end
    end else begin
      if (st.body_position == 16'd0) begin
        st_next.declared_topic_length = {rx_byte, 8'd0};
      end else if (st.body_position == 16'd1) begin
        st_next.declared_topic_length = {st.declared_topic_length[15:8], rx_byte};
      end else if ({1'b0, st.body_position} < topic_end) begin
        if (may_tag && (st.body_position - 16'd2) < topic_limit) begin
          kind = mqttp_pkg::KIND_TOPIC;
        end
      end else if ({2'b0, st.body_position} >= payload_start) begin
        if (may_tag && st.kept_payload < payload_limit) begin
          kind                 = mqttp_pkg::KIND_PAYLOAD;
          st_next.kept_payload = st.kept_payload + 16'd1;
        end
      end
      st_next.body_position = mqttp_pkg::sat_inc16(st.body_position);
    end
    st_next.byte_count = mqttp_pkg::sat_inc16(st.byte_count);

    body_cnt = st_next.length_done ? st_next.body_position : 16'd0;
    need     = 18'd2 + {2'b0, st_next.declared_topic_length};
    stat     = mqttp_pkg::ST_OK;
    if (end_of_packet) begin
      priority if (over) begin
        stat = mqttp_pkg::ST_TOO_LONG;
      end else if (st.byte_count < 16'd4) begin
        stat = mqttp_pkg::ST_SHORT;
      end else if (!is_pub) begin
        stat = mqttp_pkg::ST_NOT_PUBLISH;
      end else if ({16'd0, body_cnt} < st_next.remaining_length) begin
        stat = mqttp_pkg::ST_REM_EXCEEDS;
      end else if (body_cnt < 16'd2) begin
        stat = mqttp_pkg::ST_NO_TOPIC_LEN;
      end else if ({2'b0, body_cnt} < need) begin
        stat = mqttp_pkg::ST_TOPIC_OVERRUN;
      end else if (qos != 2'd0 && {2'b0, body_cnt} < need + 18'd2) begin
        stat = mqttp_pkg::ST_NO_PACKET_ID;
      end else begin
        stat = mqttp_pkg::ST_OK;
      end
    end

    res.byte_kind    = kind;
    res.data_byte    = (kind != mqttp_pkg::KIND_NONE) ? rx_byte : 8'd0;
    res.done_res     = end_of_packet;
    res.status       = stat;
    res.qos_level    = qos;
    res.topic_length = st_next.declared_topic_length;
    res.payload_kept = st_next.kept_payload;
  end

endmodule

/* rtl/core/mqtt_publish_packet_parser_unit.sv */
`timescale 1ns / 1ps
// MQTT PUBLISH packet parser, one packet byte per request.
// Input channel (in_valid/in_ready): rx_byte plus end_of_packet on the last
// byte of a packet. Output channel (out_valid/out_ready): one result per
// input byte, tagging kept topic and payload bytes; the result for the last
// byte carries done_res and the packet status. Tagged bytes are tentative
// until that status reads ok.
// Latency: a result is visible the cycle after its byte is taken.
// Throughput: one byte per cycle unless the receiver stalls; the per-packet
// state updates combinationally between packet state and result registers.
// A stalled receiver holds the result register; in_ready drops only while a
// result waits and out_ready is low, and rises again the cycle it is taken.
// Reset (rst, synchronous): clears packet state and the output valid, and
// sets topic capacity to 96 and payload capacity to 128.
// Config port: cfg_write with cfg_index 0 (topic capacity) or 1 (payload
// capacity); other indexes are ignored. Write only while the parser is idle.

module mqtt_publish_packet_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  byte_kind,
  output logic [7:0]  data_byte,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [1:0]  qos_level,
  output logic [15:0] topic_length,
  output logic [15:0] payload_kept
);

  mqttp_pkg::pkt_state_t pkt;
  mqttp_pkg::pkt_state_t pkt_next;
  mqttp_pkg::result_t    res;
  mqttp_pkg::result_t    res_next;
  logic [15:0]           topic_cap;
  logic [15:0]           payload_cap;
  logic                  accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  mqttp_step u_step (
    .st               (pkt),
    .rx_byte          (rx_byte),
    .end_of_packet    (end_of_packet),
    .topic_capacity   (topic_cap),
    .payload_capacity (payload_cap),
    .st_next          (pkt_next),
    .res              (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_cap   <= mqttp_pkg::TOPIC_CAP_RESET;
      payload_cap <= mqttp_pkg::PAYLOAD_CAP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == mqttp_pkg::REG_TOPIC_CAP) begin
        topic_cap <= cfg_data;
      end else if (cfg_index == mqttp_pkg::REG_PAYLOAD_CAP) begin
        payload_cap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pkt <= end_of_packet ? '0 : pkt_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign byte_kind    = res.byte_kind;
  assign data_byte    = res.data_byte;
  assign done_res     = res.done_res;
  assign status       = res.status;
  assign qos_level    = res.qos_level;
  assign topic_length = res.topic_length;
  assign payload_kept = res.payload_kept;

  a_eop_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_packet |=> pkt.byte_count == 16'd0 && pkt.kept_payload == 16'd0)
    else $error("packet state not cleared after last byte");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_packet |=> pkt.byte_count != 16'd0)
    else $error("byte count did not advance");

  a_status_at_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == mqttp_pkg::ST_OK)
    else $error("status reported before last byte");

  a_untagged_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == mqttp_pkg::KIND_NONE |-> data_byte == 8'd0)
    else $error("data on untagged byte");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == mqttp_pkg::KIND_PAYLOAD |-> payload_kept != 16'd0)
    else $error("payload byte tagged without count");

endmodule
